@@ rtl/core/arrival_time_vertex_interpolator_top_defines.svh @@
// assertion macros of the vertex interpolator rtl
`ifndef ARRIVAL_TIME_VERTEX_INTERPOLATOR_TOP_DEFINES_SVH
`define ARRIVAL_TIME_VERTEX_INTERPOLATOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, clocked by clk, off during reset
`define ATVI_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("atvi assertion failed");
// next-cycle implication
`define ATVI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("atvi assertion failed");
`else
`define ATVI_ASSERT_IMPL(lbl, ante, cons)
`define ATVI_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ rtl/core/atvi_pkg.sv @@
// types and constants of the vertex interpolator
`default_nettype none
package atvi_pkg;
  localparam logic [7:0] MAX_NEIGHBOURS = 8'd64;
  localparam logic [3:0] BASE_WEIGHT_RESET = 4'd4;
  localparam logic signed [19:0] LAMBDA_HALF = 20'sd32768;
  localparam logic signed [19:0] LAMBDA_LIMIT = 20'sd262144;
  localparam logic signed [20:0] ONE_Q16 = 21'sd65536;
  localparam int DVD_W = 49;
  localparam int DVS_W = 34;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_NB    = 2'd1,
    CMD_PASS  = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [2:0][31:0] pos;
    logic [31:0]      t1;
    logic [31:0]      t2;
    logic [31:0]      t3;
    logic             skip;
    logic             last;
  } cmd_t;
endpackage
`default_nettype wire

@@ rtl/core/atvi_if.sv @@
// request and result channels of the vertex interpolator
`default_nettype none
interface atvi_in_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic [31:0]        time_one;
  logic [31:0]        time_two;
  logic [31:0]        time_three;
  logic               skip;
  logic               last;
  modport source(output valid, req_type, pos_x, pos_y, pos_z, time_one, time_two,
                 time_three, skip, last, input ready);
  modport sink(input valid, req_type, pos_x, pos_y, pos_z, time_one, time_two,
               time_three, skip, last, output ready);
endinterface

interface atvi_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic               lambda_clipped;
  modport source(output valid, out_x, out_y, out_z, lambda_clipped, input ready);
  modport sink(input valid, out_x, out_y, out_z, lambda_clipped, output ready);
endinterface
`default_nettype wire

@@ rtl/core/atvi_front.sv @@
// request intake: classifies requests and queues them for the back end
`default_nettype none
module atvi_front import atvi_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  atvi_in_if.sink    in_ch,
  output cmd_t       cmd,
  output logic       cmd_valid,
  input  wire logic  cmd_pop
);
  cmd_t              q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push;
  logic              pop;
  cmd_t              new_cmd;

  assign in_ch.ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign push = in_ch.valid && in_ch.ready;
  assign cmd_valid = (count_r != '0);
  assign pop = cmd_pop && cmd_valid;
  assign cmd = q_r[rd_ptr_r];

  always_comb begin
    new_cmd.kind = !in_ch.req_type ? CMD_START : (in_ch.skip ? CMD_PASS : CMD_NB);
    new_cmd.pos[0] = in_ch.pos_x;
    new_cmd.pos[1] = in_ch.pos_y;
    new_cmd.pos[2] = in_ch.pos_z;
    new_cmd.t1 = in_ch.time_one;
    new_cmd.t2 = in_ch.time_two;
    new_cmd.t3 = in_ch.time_three;
    new_cmd.skip = in_ch.skip;
    new_cmd.last = in_ch.last;
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= new_cmd;
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/atvi_div.sv @@
// radix-2 restoring divider, one quotient bit per cycle
`default_nettype none
module atvi_div import atvi_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  done,
  output logic [DVD_W-1:0]      quotient
);
  localparam logic [5:0] LAST_STEP = 6'(DVD_W - 1);

  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVD_W-1:0] dvd_r;
  logic [5:0]       cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DVS_W:0]   trial;
  logic             qbit;
  logic [DVS_W:0]   diff;

  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign diff = trial - {1'b0, dvs_r};
  assign qbit = !diff[DVS_W];
  assign done = done_r;
  assign quotient = dvd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvs_r <= divisor;
      dvd_r <= dividend;
    end else if (busy_r) begin
      rem_r <= qbit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      dvd_r <= {dvd_r[DVD_W-2:0], qbit};
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/atvi_back.sv @@
// vertex state, lambda and edge point arithmetic, final averaging
`default_nettype none
`include "arrival_time_vertex_interpolator_top_defines.svh"
module atvi_back import atvi_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [3:0] base_weight,
  input  wire cmd_t       cmd,
  input  wire logic       cmd_valid,
  output logic            cmd_pop,
  atvi_out_if.source      out_ch
);
  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_LDIV   = 7'b0000010,
    ST_MUL    = 7'b0000100,
    ST_FIN    = 7'b0001000,
    ST_FSTART = 7'b0010000,
    ST_FWAIT  = 7'b0100000,
    ST_OUT    = 7'b1000000
  } state_t;

  state_t             state_r, state_nxt;
  logic signed [31:0] vpos_r [3];
  logic [31:0]        own_time_r;
  logic signed [47:0] acc_r [3];
  logic [7:0]         wc_r;
  logic               nosrc_r;
  logic               clip_r;
  logic [7:0]         taken_r;
  cmd_t               cur_r;
  logic signed [19:0] lam_r;
  logic               neg_r;
  logic [1:0]         axis_r;
  logic               phase_r;
  logic signed [53:0] m1_r, m2_r;
  logic signed [31:0] out_pos_r [3];
  logic               out_clip_r;

  logic [34:0]        n_w, d_w, n_abs, d_abs;
  logic               eligible;
  logic               div_start;
  logic               div_done;
  logic [DVD_W-1:0]   div_dvd;
  logic [DVS_W-1:0]   div_dvs;
  logic [DVD_W-1:0]   div_q;
  logic signed [47:0] seed [3];
  logic signed [4:0]  bw_s;
  logic signed [20:0] oml;
  logic signed [53:0] m1_w, m2_w, s_w, adj_w, sh_w;
  logic signed [31:0] psel;
  logic [47:0]        acc_abs;
  logic               lam_clip;
  logic [18:0]        qsat;
  logic [31:0]        avg;

  assign cmd_pop = (state_r == ST_IDLE) && cmd_valid;
  assign out_ch.valid = (state_r == ST_OUT);
  assign out_ch.out_x = out_pos_r[0];
  assign out_ch.out_y = out_pos_r[1];
  assign out_ch.out_z = out_pos_r[2];
  assign out_ch.lambda_clipped = out_clip_r;

  always_comb begin
    n_w = {3'b0, cmd.t1} - {3'b0, own_time_r};
    d_w = {3'b0, cmd.t2} - {3'b0, own_time_r} + {3'b0, cmd.t1} - {3'b0, cmd.t3};
    n_abs = n_w[34] ? -n_w : n_w;
    d_abs = d_w[34] ? -d_w : d_w;
    eligible = (cmd.kind == CMD_NB) && !nosrc_r && (taken_r < MAX_NEIGHBOURS);
    bw_s = {1'b0, base_weight};
    for (int k = 0; k < 3; k++) begin
      seed[k] = bw_s * $signed(cmd.pos[k]);
    end
    acc_abs = acc_r[axis_r][47] ? 48'(-acc_r[axis_r]) : 48'(acc_r[axis_r]);
    div_start = 1'b0;
    div_dvd = {1'b0, acc_abs};
    div_dvs = {26'b0, wc_r};
    if (state_r == ST_FSTART) begin
      div_start = 1'b1;
    end else if (cmd_pop && eligible && (d_w != '0)) begin
      div_start = 1'b1;
      div_dvd = {n_abs[32:0], 16'b0};
      div_dvs = d_abs[DVS_W-1:0];
    end
    // lambda from the unsigned quotient and its sign
    lam_clip = (div_q > DVD_W'(LAMBDA_LIMIT));
    qsat = lam_clip ? LAMBDA_LIMIT[18:0] : div_q[18:0];
    // edge point term, rounded toward zero
    oml = ONE_Q16 - 21'(lam_r);
    psel = $signed(cur_r.pos[axis_r]);
    m1_w = oml * vpos_r[axis_r];
    m2_w = lam_r * psel;
    s_w = m1_r + m2_r;
    adj_w = s_w[53] ? s_w + 54'sd65535 : s_w;
    sh_w = adj_w >>> 16;
    // saturate the averaged coordinate to 32 bits
    if (acc_r[axis_r][47]) begin
      avg = (div_q > DVD_W'(33'h080000000)) ? 32'h80000000 : 32'(-div_q[31:0]);
    end else begin
      avg = (div_q > DVD_W'(32'h7fffffff)) ? 32'h7fffffff : div_q[31:0];
    end
  end

  atvi_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          if (eligible) begin
            state_nxt = (d_w == '0) ? ST_MUL : ST_LDIV;
          end else begin
            state_nxt = cmd.last ? ST_FIN : ST_IDLE;
          end
        end
      end
      ST_LDIV: if (div_done) state_nxt = ST_MUL;
      ST_MUL: begin
        if (phase_r && (axis_r == 2'd2)) begin
          state_nxt = cur_r.last ? ST_FIN : ST_IDLE;
        end
      end
      ST_FIN: state_nxt = (nosrc_r || (wc_r == '0)) ? ST_OUT : ST_FSTART;
      ST_FSTART: state_nxt = ST_FWAIT;
      ST_FWAIT: begin
        if (div_done) begin
          state_nxt = (axis_r == 2'd2) ? ST_OUT : ST_FSTART;
        end
      end
      ST_OUT: if (out_ch.ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      own_time_r <= '0;
      wc_r <= '0;
      nosrc_r <= 1'b0;
      clip_r <= 1'b0;
      taken_r <= '0;
      for (int k = 0; k < 3; k++) begin
        vpos_r[k] <= '0;
        acc_r[k] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cmd_pop && (cmd.kind == CMD_START)) begin
        for (int k = 0; k < 3; k++) begin
          vpos_r[k] <= $signed(cmd.pos[k]);
          acc_r[k] <= seed[k];
        end
        own_time_r <= cmd.t1;
        nosrc_r <= cmd.skip;
        wc_r <= {4'b0, base_weight};
        clip_r <= 1'b0;
        taken_r <= '0;
      end
      if ((state_r == ST_LDIV) && div_done) begin
        clip_r <= clip_r | lam_clip;
      end
      if ((state_r == ST_MUL) && phase_r) begin
        acc_r[axis_r] <= acc_r[axis_r] + 48'(sh_w);
        if (axis_r == 2'd2) begin
          wc_r <= wc_r + 8'd1;
          taken_r <= taken_r + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur_r <= cmd;
      neg_r <= n_w[34] ^ d_w[34];
      lam_r <= LAMBDA_HALF;
      axis_r <= '0;
      phase_r <= 1'b0;
    end
    if ((state_r == ST_LDIV) && div_done) begin
      lam_r <= neg_r ? -20'(qsat) : 20'(qsat);
    end
    if (state_r == ST_MUL) begin
      if (!phase_r) begin
        m1_r <= m1_w;
        m2_r <= m2_w;
      end else begin
        axis_r <= axis_r + 2'd1;
      end
      phase_r <= !phase_r;
    end
    if (state_r == ST_FIN) begin
      axis_r <= '0;
      for (int k = 0; k < 3; k++) begin
        out_pos_r[k] <= vpos_r[k];
      end
      out_clip_r <= nosrc_r ? 1'b0 : clip_r;
    end
    if ((state_r == ST_FWAIT) && div_done) begin
      out_pos_r[axis_r] <= avg;
      axis_r <= axis_r + 2'd1;
    end
  end

  `ATVI_ASSERT_IMPL(a_div_start_state, div_start, (state_r == ST_IDLE) || (state_r == ST_FSTART))
  `ATVI_ASSERT_IMPL(a_div_done_state, div_done, (state_r == ST_LDIV) || (state_r == ST_FWAIT))
  `ATVI_ASSERT_IMPL(a_lam_range, state_r == ST_MUL, (lam_r <= LAMBDA_LIMIT) && (lam_r >= -LAMBDA_LIMIT))
  `ATVI_ASSERT_NEXT(a_out_hold, (state_r == ST_OUT) && !out_ch.ready, state_r == ST_OUT)
endmodule
`default_nettype wire

@@ rtl/core/arrival_time_vertex_interpolator_top.sv @@
// Vertex interpolator top level. Requests enter a two-entry queue and are
// worked one at a time by the back end. A neighbour runs one 49-step
// radix-2 division for lambda, then a multiply step and an accumulate step
// per axis; no division is run when its divisor is zero, and a skipped
// neighbour does no arithmetic. A request marked last also forms an
// average on each axis, unless the vertex has no source or no weight,
// with the same divider, which then runs once per axis. Results wait in
// an output register; the queue keeps taking requests meanwhile until
// its two entries are full.
`default_nettype none
module arrival_time_vertex_interpolator_top import atvi_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  atvi_in_if.sink         in_ch,
  atvi_out_if.source      out_ch,
  input  wire logic       cfg_we,
  input  wire logic [3:0] cfg_wdata
);
  logic [3:0] base_weight_r;
  cmd_t       cmd;
  logic       cmd_valid;
  logic       cmd_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_weight_r <= BASE_WEIGHT_RESET;
    end else if (cfg_we) begin
      base_weight_r <= cfg_wdata;
    end
  end

  atvi_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop)
  );

  atvi_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .base_weight (base_weight_r),
    .cmd         (cmd),
    .cmd_valid   (cmd_valid),
    .cmd_pop     (cmd_pop),
    .out_ch      (out_ch)
  );
endmodule
`default_nettype wire
